// ===== sv/ssec_pkg.sv =====
// ----------------------------------------------------------------------------
// ssec_pkg: shared types and constants of the sequence store
// Beat types of both channels, request and status codes, sequencer states,
// and the ring index adder.
// ----------------------------------------------------------------------------
`default_nettype none

package ssec_pkg;

	localparam int CAPACITY = 16;
	localparam int IDX_W    = $clog2(CAPACITY);
	localparam int CNT_W    = $clog2(CAPACITY + 1);
	localparam int SUM_W    = IDX_W + 1;

	localparam int REQ_W  = 3;
	localparam int VAL_W  = 32;
	localparam int POS_W  = 5;
	localparam int LEN_W  = 5;
	localparam int STAT_W = 2;
	localparam int KW     = (POS_W > CNT_W) ? POS_W : CNT_W;

	localparam logic [CNT_W-1:0] CAP_CNT = CNT_W'(CAPACITY);
	localparam logic [SUM_W-1:0] CAP_SUM = SUM_W'(CAPACITY);

	typedef logic [IDX_W-1:0] idx_t;
	typedef logic [CNT_W-1:0] cnt_t;

	// request codes
	localparam logic [REQ_W-1:0] REQ_INS_BACK  = 3'd0;
	localparam logic [REQ_W-1:0] REQ_INS_FRONT = 3'd1;
	localparam logic [REQ_W-1:0] REQ_DEL_BACK  = 3'd2;
	localparam logic [REQ_W-1:0] REQ_DEL_FRONT = 3'd3;
	localparam logic [REQ_W-1:0] REQ_DEL_POS   = 3'd4;

	// status codes
	localparam logic [STAT_W-1:0] STAT_OK    = 2'd0;
	localparam logic [STAT_W-1:0] STAT_FULL  = 2'd1;
	localparam logic [STAT_W-1:0] STAT_EMPTY = 2'd2;

	typedef struct packed {
		logic [REQ_W-1:0]        req_type;
		logic signed [VAL_W-1:0] value;
		logic [POS_W-1:0]        position;
	} req_beat_t;

	typedef struct packed {
		logic [LEN_W-1:0]  length;
		logic [LEN_W-1:0]  even_count;
		logic [STAT_W-1:0] status;
	} rsp_beat_t;

	typedef struct packed {
		logic             we;
		idx_t             waddr;
		logic [VAL_W-1:0] wdata;
		logic             re;
		idx_t             raddr;
	} ram_cmd_t;

	typedef struct packed {
		logic idle;
		logic done;
	} seq_stat_t;

	typedef enum logic [2:0] {
		SEQ_IDLE,
		SEQ_DECODE,
		SEQ_CHECK,
		SEQ_SHIFT,
		SEQ_FINISH
	} seq_state_t;

	// (a + b) mod CAPACITY for a, b < CAPACITY
	function automatic idx_t ring_add(input idx_t a, input idx_t b);
		logic [SUM_W-1:0] sum;
		sum = {1'b0, a} + {1'b0, b};
		if (sum >= CAP_SUM)
			sum = sum - CAP_SUM;
		return sum[IDX_W-1:0];
	endfunction

	function automatic idx_t ring_inc(input idx_t a);
		return ring_add(a, IDX_W'(1));
	endfunction

endpackage

`default_nettype wire

// ===== sv/ssec_ram.sv =====
// ----------------------------------------------------------------------------
// ssec_ram: simple dual-port RAM
// One write port and one read port, registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module ssec_ram #(
	parameter int DEPTH = 16,
	parameter int WIDTH = 32
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output      logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we)
			mem[waddr] <= wdata;
	end

	always_ff @(posedge clk) begin
		if (re)
			rdata <= mem[raddr];
	end

endmodule

`default_nettype wire

// ===== sv/ssec_seq.sv =====
// ----------------------------------------------------------------------------
// ssec_seq: request sequencer of the sequence store
// Holds head, length and even count, and steps the ring RAM one entry
// per cycle through the read and shift work of each request.
// ----------------------------------------------------------------------------
`default_nettype none

module ssec_seq
	import ssec_pkg::*;
(
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             start,
	input  wire req_beat_t        req,
	input  wire logic             out_free,
	input  wire logic [VAL_W-1:0] rdata,
	output      ram_cmd_t         ram_cmd,
	output      seq_stat_t        stat,
	output      rsp_beat_t        result
);

	seq_state_t        state_q, state_d;
	idx_t              head_q, head_d;
	cnt_t              count_q, count_d;
	cnt_t              even_q, even_d;
	logic [STAT_W-1:0] status_q, status_d;

	req_beat_t req_q, req_d;
	idx_t      slot_q, slot_d;
	idx_t      rd_slot_q, rd_slot_d;
	cnt_t      rem_q, rem_d;

	logic          is_ins, is_del, is_front;
	logic [KW-1:0] pos_k, last_k, k_sel;
	idx_t          offset, target;
	idx_t          next_slot;

	// operand selection for the ring adder
	always_comb begin
		is_ins   = (req_q.req_type == REQ_INS_BACK) || (req_q.req_type == REQ_INS_FRONT);
		is_del   = req_q.req_type inside {REQ_DEL_BACK, REQ_DEL_FRONT, REQ_DEL_POS};
		is_front = (req_q.req_type == REQ_DEL_FRONT);
		pos_k    = (req_q.position == '0) ? '0 : KW'(req_q.position - POS_W'(1));
		last_k   = KW'(count_q - CNT_W'(1));
		k_sel    = (pos_k > last_k) ? last_k : pos_k;
		case (req_q.req_type)
			REQ_INS_BACK:  offset = count_q[IDX_W-1:0];
			REQ_INS_FRONT: offset = IDX_W'(CAPACITY - 1);
			REQ_DEL_BACK:  offset = last_k[IDX_W-1:0];
			REQ_DEL_FRONT: offset = '0;
			REQ_DEL_POS:   offset = k_sel[IDX_W-1:0];
			default:       offset = '0;
		endcase
		target    = ring_add(head_q, offset);
		next_slot = ring_inc(slot_q);
	end

	always_comb begin
		state_d   = state_q;
		head_d    = head_q;
		count_d   = count_q;
		even_d    = even_q;
		status_d  = status_q;
		req_d     = req_q;
		slot_d    = slot_q;
		rd_slot_d = rd_slot_q;
		rem_d     = rem_q;
		ram_cmd       = '0;
		ram_cmd.wdata = req_q.value;
		stat.idle     = 1'b0;
		stat.done     = 1'b0;

		case (state_q)
			SEQ_IDLE: begin
				stat.idle = 1'b1;
				if (start) begin
					req_d    = req;
					status_d = STAT_OK;
					state_d  = SEQ_DECODE;
				end
			end
			SEQ_DECODE: begin
				state_d = SEQ_FINISH;
				if (is_ins) begin
					if (count_q == CAP_CNT) begin
						status_d = STAT_FULL;
					end else begin
						ram_cmd.we    = 1'b1;
						ram_cmd.waddr = target;
						count_d       = count_q + CNT_W'(1);
						even_d        = even_q + CNT_W'(!req_q.value[0]);
						if (req_q.req_type == REQ_INS_FRONT)
							head_d = target;
					end
				end else if (is_del) begin
					if (count_q == '0) begin
						status_d = STAT_EMPTY;
					end else begin
						ram_cmd.re    = 1'b1;
						ram_cmd.raddr = target;
						slot_d        = target;
						// only a position delete has followers to move
						rem_d         = (req_q.req_type == REQ_DEL_POS)
							? CNT_W'(last_k - k_sel) : '0;
						state_d       = SEQ_CHECK;
					end
				end
			end
			SEQ_CHECK: begin
				// rdata holds the entry being removed
				even_d  = even_q - CNT_W'(!rdata[0]);
				count_d = count_q - CNT_W'(1);
				if (count_q == CNT_W'(1))
					head_d = '0;
				else if (is_front)
					head_d = ring_inc(head_q);
				if (rem_q == '0) begin
					state_d = SEQ_FINISH;
				end else begin
					ram_cmd.re    = 1'b1;
					ram_cmd.raddr = next_slot;
					rd_slot_d     = ring_inc(next_slot);
					state_d       = SEQ_SHIFT;
				end
			end
			SEQ_SHIFT: begin
				// move the follower one place toward the front
				ram_cmd.we    = 1'b1;
				ram_cmd.waddr = slot_q;
				ram_cmd.wdata = rdata;
				slot_d        = next_slot;
				rem_d         = rem_q - CNT_W'(1);
				if (rem_q == CNT_W'(1)) begin
					state_d = SEQ_FINISH;
				end else begin
					ram_cmd.re    = 1'b1;
					ram_cmd.raddr = rd_slot_q;
					rd_slot_d     = ring_inc(rd_slot_q);
				end
			end
			SEQ_FINISH: begin
				if (out_free) begin
					stat.done = 1'b1;
					state_d   = SEQ_IDLE;
				end
			end
			default: begin
				state_d = SEQ_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= SEQ_IDLE;
			head_q   <= '0;
			count_q  <= '0;
			even_q   <= '0;
			status_q <= STAT_OK;
		end else begin
			state_q  <= state_d;
			head_q   <= head_d;
			count_q  <= count_d;
			even_q   <= even_d;
			status_q <= status_d;
		end
	end

	always_ff @(posedge clk) begin
		req_q     <= req_d;
		slot_q    <= slot_d;
		rd_slot_q <= rd_slot_d;
		rem_q     <= rem_d;
	end

	assign result.length     = LEN_W'(count_q);
	assign result.even_count = LEN_W'(even_q);
	assign result.status     = status_q;

`ifndef SYNTHESIS
	a_even_le_count: assert property (@(posedge clk) disable iff (!arst_n)
		even_q <= count_q)
		else $error("even count exceeds length");

	a_count_le_cap: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CAP_CNT)
		else $error("length exceeds capacity");

	a_empty_head: assert property (@(posedge clk) disable iff (!arst_n)
		(count_q == '0) |-> (head_q == '0))
		else $error("empty store with nonzero head");

	a_shift_writes: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == SEQ_SHIFT) |-> (ram_cmd.we && rem_q != '0))
		else $error("shift step without pending move");

	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		stat.done |=> (state_q == SEQ_IDLE))
		else $error("sequencer not idle after result");
`endif

endmodule

`default_nettype wire

// ===== sv/sequence_store_even_count_top.sv =====
// ----------------------------------------------------------------------------
// sequence_store_even_count_top: bounded ring sequence with even count
// Insert back/front, delete back/front/at position on a ring of signed
// 32-bit entries; each request beat returns length, even count and status.
// ----------------------------------------------------------------------------
//  channel | dir | handshake           | payload
//  --------+-----+---------------------+-------------------------------------
//  req     | in  | req_valid/req_ready | req_type, value, position
//  rsp     | out | rsp_valid/rsp_ready | length, even_count, status
//
//  An insert, an unused code or a delete on an empty store steps from
//  decode to finish; delete back/front also passes the check step, and
//  delete at position then shifts each entry after the deleted one. The
//  position delete moves one entry per cycle through the ring RAM's single
//  write port.
//  Reset clears head, length and even count; the RAM is not cleared.
//  A result held in the rsp register lets the next request run; the
//  sequencer stalls in its last step only if that register is still full.
// ----------------------------------------------------------------------------
`default_nettype none

module sequence_store_even_count_top
	import ssec_pkg::*;
(
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      req_valid,
	output      logic      req_ready,
	input  wire req_beat_t req,
	output      logic      rsp_valid,
	input  wire logic      rsp_ready,
	output      rsp_beat_t rsp
);

	ram_cmd_t         ram_cmd;
	seq_stat_t        seq_stat;
	rsp_beat_t        seq_result;
	logic [VAL_W-1:0] ram_rdata;
	logic             start;
	logic             out_free;
	logic             rsp_valid_q;
	rsp_beat_t        rsp_q;

	// request beat taken only while the sequencer is idle
	assign req_ready = seq_stat.idle;
	assign start     = req_valid && req_ready;

	// result register frees up in the same cycle its beat is taken
	assign out_free = !rsp_valid_q || rsp_ready;

	ssec_seq u_seq (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (start),
		.req      (req),
		.out_free (out_free),
		.rdata    (ram_rdata),
		.ram_cmd  (ram_cmd),
		.stat     (seq_stat),
		.result   (seq_result)
	);

	ssec_ram #(
		.DEPTH (CAPACITY),
		.WIDTH (VAL_W)
	) u_ram (
		.clk   (clk),
		.we    (ram_cmd.we),
		.waddr (ram_cmd.waddr),
		.wdata (ram_cmd.wdata),
		.re    (ram_cmd.re),
		.raddr (ram_cmd.raddr),
		.rdata (ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (seq_stat.done) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp_ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (seq_stat.done)
			rsp_q <= seq_result;
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

endmodule

`default_nettype wire
